// ----- sv/dma_buffer_ring_with_underrun_restart_top_macros.svh -----
// Assertion macros for the DMA buffer ring.
// Included by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef DMA_BUFFER_RING_WITH_UNDERRUN_RESTART_TOP_MACROS_SVH
`define DMA_BUFFER_RING_WITH_UNDERRUN_RESTART_TOP_MACROS_SVH

// Combinational property sampled at every edge outside reset.
`define DBR_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication from one edge to the next, outside reset.
`define DBR_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dbr_pkg.sv -----
// Shared types and constants for the DMA buffer ring.
// No dependencies.
`default_nettype none
package dbr_pkg;

  localparam int RING_DEPTH_DEFAULT = 4;
  localparam int SPB_W              = 16;
  localparam int ADDR_W             = 32;
  localparam int LEN_W              = 18;
  localparam int LEVEL_W            = 3;
  localparam logic [SPB_W-1:0] SPB_RESET = 16'd1;

  typedef enum logic [2:0] {
    OP_REFILL = 3'd0,
    OP_DONE   = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_EMPTY  = 3'd4
  } op_t;

  // byte length of one buffer: four bytes per stereo sample
  function automatic logic [LEN_W-1:0] buf_bytes(input logic [SPB_W-1:0] spb);
    buf_bytes = {spb, 2'b00};
  endfunction

endpackage
`default_nettype wire

// ----- sv/dbr_ring.sv -----
// Address ring storage: one write port, two registered read ports with write bypass.
// Uses dbr_pkg for the address width.
`default_nettype none
module dbr_ring
  import dbr_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT,
  localparam int IW = $clog2(RING_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              upd,
  input  wire logic              wr_en,
  input  wire logic [IW-1:0]     wr_idx,
  input  wire logic [ADDR_W-1:0] wr_data,
  input  wire logic [IW-1:0]     rd_idx0,
  input  wire logic [IW-1:0]     rd_idx1,
  output logic      [ADDR_W-1:0] rd_data0,
  output logic      [ADDR_W-1:0] rd_data1
);

  logic [ADDR_W-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (upd && wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // read data follows the pointers as they stand after this beat
  always_ff @(posedge clk) begin
    if (upd) begin
      rd_data0 <= (wr_en && wr_idx == rd_idx0) ? wr_data : mem[rd_idx0];
      rd_data1 <= (wr_en && wr_idx == rd_idx1) ? wr_data : mem[rd_idx1];
    end
  end

endmodule
`default_nettype wire

// ----- sv/dma_buffer_ring_with_underrun_restart_top.sv -----
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     opcode, buffer_address
// out      output     out_valid / out_ready   accepted .. level
// cfg      input      cfg_write               cfg_data (samples per buffer)
//
// One beat in, one beat out; a new beat is taken every cycle while the result
// register is empty or being drained. The result is held in the result register.
// Ring reads come from the registered head and next-entry ports of dbr_ring.
// Synchronous reset clears pointers, count, flags and the result valid; no clearing pass.
// Depends on dbr_pkg, dbr_ring and the assertion macro header.
`default_nettype none
`include "dma_buffer_ring_with_underrun_restart_top_macros.svh"
module dma_buffer_ring_with_underrun_restart_top
  import dbr_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [SPB_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         opcode,
  input  wire logic [ADDR_W-1:0]  buffer_address,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    accepted,
  output logic                    dma_start,
  output logic      [ADDR_W-1:0]  dma_address,
  output logic      [LEN_W-1:0]   dma_length,
  output logic                    completed_valid,
  output logic      [ADDR_W-1:0]  completed_address,
  output logic                    underrun,
  output logic                    active,
  output logic      [LEVEL_W-1:0] level
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    ring_next = (i == IW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [SPB_W-1:0]  spb;
  logic [IW-1:0]     widx, widx_next;
  logic [IW-1:0]     ridx, ridx_next;
  logic [CW-1:0]     count, count_next;
  logic              starved, starved_next;
  logic              running, running_next;

  logic [ADDR_W-1:0] head_addr, second_addr;
  logic              take;
  logic              wr_en;
  logic              acc_c, launch_c, done_c;
  logic [ADDR_W-1:0] launch_addr_c, done_addr_c;
  op_t               op;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign op       = op_t'(opcode);

  always_comb begin
    widx_next     = widx;
    ridx_next     = ridx;
    count_next    = count;
    starved_next  = starved;
    running_next  = running;
    wr_en         = 1'b0;
    acc_c         = 1'b0;
    launch_c      = 1'b0;
    launch_addr_c = '0;
    done_c        = 1'b0;
    done_addr_c   = '0;
    unique case (op)
      OP_REFILL: begin
        if (count < CW'(RING_DEPTH)) begin
          wr_en      = 1'b1;
          widx_next  = ring_next(widx);
          count_next = count + 1'b1;
          acc_c      = 1'b1;
          if (starved) begin
            starved_next  = 1'b0;
            launch_c      = 1'b1;
            launch_addr_c = buffer_address;
            running_next  = 1'b1;
          end
        end
      end
      OP_DONE: begin
        if (count != '0) begin
          done_c       = 1'b1;
          done_addr_c  = head_addr;
          ridx_next    = ring_next(ridx);
          count_next   = count - 1'b1;
          running_next = 1'b1;
          if (count != CW'(1)) begin
            launch_c      = 1'b1;
            launch_addr_c = second_addr;
          end else begin
            starved_next = 1'b1;
          end
        end
      end
      OP_START: begin
        if (!running) begin
          acc_c = 1'b1;
          if (count != '0) begin
            launch_c      = 1'b1;
            launch_addr_c = head_addr;
            running_next  = 1'b1;
          end else begin
            starved_next = 1'b1;
          end
        end
      end
      OP_STOP: begin
        running_next = 1'b0;
      end
      OP_EMPTY: begin
        widx_next    = '0;
        ridx_next    = '0;
        count_next   = '0;
        starved_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  dbr_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .upd      (take),
    .wr_en    (wr_en),
    .wr_idx   (widx),
    .wr_data  (buffer_address),
    .rd_idx0  (ridx_next),
    .rd_idx1  (ring_next(ridx_next)),
    .rd_data0 (head_addr),
    .rd_data1 (second_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      spb <= SPB_RESET;
    end else if (cfg_write) begin
      spb <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx    <= '0;
      ridx    <= '0;
      count   <= '0;
      starved <= 1'b0;
      running <= 1'b0;
    end else if (take) begin
      widx    <= widx_next;
      ridx    <= ridx_next;
      count   <= count_next;
      starved <= starved_next;
      running <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (take) begin
      accepted          <= acc_c;
      dma_start         <= launch_c;
      dma_address       <= launch_addr_c;
      dma_length        <= launch_c ? buf_bytes(spb) : '0;
      completed_valid   <= done_c;
      completed_address <= done_addr_c;
      underrun          <= starved_next;
      active            <= running_next;
      level             <= LEVEL_W'(count_next);
    end
  end

  `DBR_CHECK(a_count_bound, count <= CW'(RING_DEPTH), "fill count beyond ring depth")
  `DBR_CHECK(a_empty_ptrs, (count != '0) || (widx == ridx), "empty ring with split pointers")
  `DBR_CHECK(a_starved_empty, !starved || (count == '0), "underrun with buffers queued")
  `DBR_CHECK(a_launch_active, !(out_valid && dma_start) || active, "launch while inactive")
  `DBR_CHECK_NEXT(a_stall_state, !take, $stable(count) && $stable(ridx) && $stable(widx),
                  "ring state moved without a beat")

endmodule
`default_nettype wire
